// File: rtl/core/pslc_pkg.sv
// ----------------------------------------------------------------------------
// pslc_pkg
// Shared widths and register indexes of the slew-limited PID controller.
// ----------------------------------------------------------------------------
package pslc_pkg;

    // Integral accumulator width, 32 to 64
    localparam int PSLC_IB      = 48;

    // Serial multiplier: wide multiplicand, bit-serial multiplier operand
    localparam int PSLC_A_W     = 64;
    localparam int PSLC_B_W     = 24;
    localparam int PSLC_P_W     = PSLC_A_W + PSLC_B_W;

    // Serial divider: dividend and divisor widths
    localparam int PSLC_N_W     = 64;
    localparam int PSLC_DEN_W   = 16;

    // Configuration port
    localparam int PSLC_CFG_IDX_W = 3;
    localparam int PSLC_CFG_W     = 24;

    typedef enum logic [PSLC_CFG_IDX_W-1:0] {
        CFG_GAIN_P = 3'd0,
        CFG_GAIN_I = 3'd1,
        CFG_GAIN_D = 3'd2,
        CFG_SLEW   = 3'd3,
        CFG_TARGET = 3'd4
    } t_cfg_idx;

endpackage

// File: rtl/core/pslc_mul.sv
// ----------------------------------------------------------------------------
// pslc_mul
// Shift-add multiplier, one bit of the multiplier operand per cycle.
// ----------------------------------------------------------------------------
module pslc_mul import pslc_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [PSLC_A_W-1:0] i_a,
    input  logic [PSLC_B_W-1:0] i_b,
    output logic                o_done,
    output logic [PSLC_P_W-1:0] o_p
);

    localparam int CNT_W = $clog2(PSLC_B_W);

    logic                r_busy;
    logic                r_done;
    logic [CNT_W-1:0]    r_cnt;
    logic [PSLC_P_W-1:0] r_acc;
    logic [PSLC_P_W-1:0] r_a;
    logic [PSLC_B_W-1:0] r_b;

    // Control: run for one pass over the multiplier bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(PSLC_B_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: add the shifted multiplicand when the current bit is set
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= '0;
            r_a   <= PSLC_P_W'(i_a);
            r_b   <= i_b;
        end else if (r_busy) begin
            if (r_b[0]) begin
                r_acc <= r_acc + r_a;
            end
            r_a <= r_a << 1;
            r_b <= r_b >> 1;
        end
    end

    assign o_done = r_done;
    assign o_p    = r_acc;

endmodule

// File: rtl/core/pslc_div.sv
// ----------------------------------------------------------------------------
// pslc_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pslc_div import pslc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [PSLC_N_W-1:0]   i_num,
    input  logic [PSLC_DEN_W-1:0] i_den,
    output logic                  o_done,
    output logic [PSLC_N_W-1:0]   o_quo
);

    localparam int CNT_W = $clog2(PSLC_N_W);

    logic                  r_busy;
    logic                  r_done;
    logic [CNT_W-1:0]      r_cnt;
    logic [PSLC_N_W-1:0]   r_num;
    logic [PSLC_DEN_W-1:0] r_den;
    logic [PSLC_DEN_W-1:0] r_rem;
    logic [PSLC_DEN_W:0]   shifted;
    logic [PSLC_DEN_W:0]   trial;
    logic                  fits;

    // Bring down the next dividend bit and try the subtraction
    assign shifted = {r_rem, r_num[PSLC_N_W-1]};
    assign trial   = shifted - {1'b0, r_den};
    assign fits    = (shifted >= {1'b0, r_den});

    // Control: one pass over the dividend bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(PSLC_N_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: quotient bits shift in behind the dividend
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= fits ? trial[PSLC_DEN_W-1:0] : shifted[PSLC_DEN_W-1:0];
            r_num <= {r_num[PSLC_N_W-2:0], fits};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_num;

endmodule

// File: rtl/core/pid_slew_limited_controller.sv
// ----------------------------------------------------------------------------
// pid_slew_limited_controller
// PID controller with integral saturation and output slew-rate limit.
// ----------------------------------------------------------------------------
// One transaction in, one drive value out. The first transaction after reset
// only arms the controller and a transaction with zero elapsed time leaves
// the state alone; both go straight to the output state and answer zero. A
// regular update runs six passes of the bit-serial multiplier and three
// passes of the bit-serial divider in sequence, then sums, clamps and loads
// the output; those two shared units set the rate. One transaction is in
// work at a time; the next is taken while the previous drive still waits in
// the output register. Write the configuration only while the block is idle.
// ----------------------------------------------------------------------------
module pid_slew_limited_controller import pslc_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // configuration
    input  logic                      i_cfg_wr_en,
    input  logic [PSLC_CFG_IDX_W-1:0] i_cfg_index,
    input  logic [PSLC_CFG_W-1:0]     i_cfg_data,
    // input channel
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic signed [23:0]        i_measured,
    input  logic [15:0]               i_elapsed_ms,
    // output channel
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic signed [15:0]        o_drive
);

    localparam int SUM_W = PSLC_A_W + 2;
    localparam logic signed [SUM_W-1:0] SMAX = (SUM_W'(1) << (PSLC_IB - 1)) - SUM_W'(1);
    localparam logic signed [SUM_W-1:0] SMIN = -SMAX - SUM_W'(1);
    localparam logic [PSLC_P_W-1:0]     ISAT = PSLC_P_W'(1) << 62;
    localparam logic [PSLC_B_W-1:0]     K1000 = PSLC_B_W'(1000);
    localparam logic signed [49:0]      DRIVE_MAX = 50'sd32512;

    typedef enum logic [12:0] {
        S_IDLE  = 13'b0000000000001,
        S_INC   = 13'b0000000000010,
        S_P     = 13'b0000000000100,
        S_I     = 13'b0000000001000,
        S_IDIV  = 13'b0000000010000,
        S_D1    = 13'b0000000100000,
        S_D2    = 13'b0000001000000,
        S_DDIV  = 13'b0000010000000,
        S_MC    = 13'b0000100000000,
        S_MCDIV = 13'b0001000000000,
        S_SUM   = 13'b0010000000000,
        S_CLAMP = 13'b0100000000000,
        S_OUT   = 13'b1000000000000
    } t_state;

    t_state                     r_state;

    // configuration registers
    logic [23:0]                r_gain_p;
    logic [23:0]                r_gain_i;
    logic [23:0]                r_gain_d;
    logic [23:0]                r_slew;
    logic signed [23:0]         r_target;

    // controller state
    logic                       r_armed;
    logic signed [PSLC_IB-1:0]  r_esum;
    logic signed [24:0]         r_prev_err;
    logic signed [15:0]         r_prev_drive;

    // per-transaction working registers
    logic [15:0]                r_ms;
    logic signed [24:0]         r_err;
    logic                       r_neg;
    logic signed [63:0]         r_p;
    logic signed [63:0]         r_i;
    logic signed [63:0]         r_d;
    logic [30:0]                r_mc;
    logic signed [47:0]         r_sum;
    logic signed [15:0]         r_result;

    // shared unit handshake
    logic                       r_mul_start;
    logic [PSLC_A_W-1:0]        r_mul_a;
    logic [PSLC_B_W-1:0]        r_mul_b;
    logic                       r_div_start;
    logic [PSLC_N_W-1:0]        r_div_num;
    logic [PSLC_DEN_W-1:0]      r_div_den;
    logic                       mul_done;
    logic [PSLC_P_W-1:0]        mul_p;
    logic                       div_done;
    logic [PSLC_N_W-1:0]        div_q;

    // output register
    logic                       r_out_valid;
    logic signed [15:0]         r_drive;

    // combinational helpers
    logic                       in_acc;
    logic                       out_free;
    logic signed [24:0]         err_now;
    logic [24:0]                err_mag;
    logic signed [SUM_W-1:0]    inc_ext;
    logic signed [SUM_W-1:0]    esum_new;
    logic signed [PSLC_IB-1:0]  esum_sat;
    logic signed [63:0]         esum64;
    logic [63:0]                esum_mag;
    logic signed [25:0]         derr;
    logic [25:0]                derr_mag;
    logic [PSLC_P_W-1:0]        i_prod_sat;
    logic signed [63:0]         quo_signed;
    logic signed [63:0]         tot;
    logic [63:0]                tot_mag;
    logic [47:0]                tot_shift;
    logic signed [49:0]         sum_ext;
    logic signed [49:0]         lim_lo;
    logic signed [49:0]         lim_hi;
    logic signed [49:0]         slewed;
    logic signed [49:0]         clamped;

    // Magnitude of a stored error
    function automatic logic [24:0] err_mag_reg(input logic signed [24:0] e);
        err_mag_reg = e[24] ? 25'(-e) : e;
    endfunction

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;

    // Error and its magnitude for the first multiply
    assign err_now  = 25'(r_target) - 25'(i_measured);
    assign err_mag  = err_now[24] ? 25'(-err_now) : err_now;

    // Saturating integral update
    assign inc_ext  = r_neg ? -SUM_W'(mul_p[40:0]) : SUM_W'(mul_p[40:0]);
    assign esum_new = SUM_W'(r_esum) + inc_ext;
    always_comb begin
        priority if (esum_new > SMAX) begin
            esum_sat = PSLC_IB'(SMAX);
        end else if (esum_new < SMIN) begin
            esum_sat = PSLC_IB'(SMIN);
        end else begin
            esum_sat = PSLC_IB'(esum_new);
        end
    end

    assign esum64   = 64'(r_esum);
    assign esum_mag = esum64[63] ? 64'(-esum64) : esum64;

    assign derr     = 26'(r_err) - 26'(r_prev_err);
    assign derr_mag = derr[25] ? 26'(-derr) : derr;

    assign i_prod_sat = (mul_p > ISAT) ? ISAT : mul_p;
    assign quo_signed = r_neg ? -$signed(div_q) : $signed(div_q);

    // Sum of terms, scaled to Q8.8 with truncation toward zero
    assign tot       = r_p + r_i + r_d;
    assign tot_mag   = tot[63] ? 64'(-tot) : tot;
    assign tot_shift = tot_mag[63:16];

    // Slew window around the last drive, then the fixed output range
    assign sum_ext = 50'(r_sum);
    assign lim_lo  = 50'(r_prev_drive) - $signed(50'(r_mc));
    assign lim_hi  = 50'(r_prev_drive) + $signed(50'(r_mc));
    always_comb begin
        priority if (sum_ext < lim_lo) begin
            slewed = lim_lo;
        end else if (sum_ext > lim_hi) begin
            slewed = lim_hi;
        end else begin
            slewed = sum_ext;
        end
        priority if (slewed < -DRIVE_MAX) begin
            clamped = -DRIVE_MAX;
        end else if (slewed > DRIVE_MAX) begin
            clamped = DRIVE_MAX;
        end else begin
            clamped = slewed;
        end
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_p <= '0;
            r_gain_i <= '0;
            r_gain_d <= '0;
            r_slew   <= '0;
            r_target <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_GAIN_P: r_gain_p <= i_cfg_data;
                CFG_GAIN_I: r_gain_i <= i_cfg_data;
                CFG_GAIN_D: r_gain_d <= i_cfg_data;
                CFG_SLEW:   r_slew   <= i_cfg_data;
                CFG_TARGET: r_target <= $signed(i_cfg_data);
                default: ;
            endcase
        end
    end

    // Sequencer over the shared multiplier and divider
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_armed      <= 1'b0;
            r_esum       <= '0;
            r_prev_err   <= '0;
            r_prev_drive <= '0;
            r_mul_start  <= 1'b0;
            r_div_start  <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_mul_start <= 1'b0;
            r_div_start <= 1'b0;
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_ms  <= i_elapsed_ms;
                        r_err <= err_now;
                        r_neg <= err_now[24];
                        if (!r_armed) begin
                            r_armed      <= 1'b1;
                            r_prev_drive <= '0;
                            r_result     <= '0;
                            r_state      <= S_OUT;
                        end else if (i_elapsed_ms == '0) begin
                            r_result <= '0;
                            r_state  <= S_OUT;
                        end else begin
                            r_mul_a     <= PSLC_A_W'(err_mag);
                            r_mul_b     <= PSLC_B_W'(i_elapsed_ms);
                            r_mul_start <= 1'b1;
                            r_state     <= S_INC;
                        end
                    end
                end
                S_INC: begin
                    if (mul_done) begin
                        r_esum      <= esum_sat;
                        r_mul_a     <= PSLC_A_W'(err_mag_reg(r_err));
                        r_mul_b     <= r_gain_p;
                        r_mul_start <= 1'b1;
                        r_state     <= S_P;
                    end
                end
                S_P: begin
                    if (mul_done) begin
                        r_p         <= r_neg ? -$signed(64'(mul_p[48:0]))
                                             : $signed(64'(mul_p[48:0]));
                        r_neg       <= r_esum[PSLC_IB-1];
                        r_mul_a     <= esum_mag;
                        r_mul_b     <= r_gain_i;
                        r_mul_start <= 1'b1;
                        r_state     <= S_I;
                    end
                end
                S_I: begin
                    if (mul_done) begin
                        r_div_num   <= i_prod_sat[PSLC_N_W-1:0];
                        r_div_den   <= PSLC_DEN_W'(K1000);
                        r_div_start <= 1'b1;
                        r_state     <= S_IDIV;
                    end
                end
                S_IDIV: begin
                    if (div_done) begin
                        r_i         <= quo_signed;
                        r_neg       <= derr[25];
                        r_mul_a     <= PSLC_A_W'(derr_mag);
                        r_mul_b     <= r_gain_d;
                        r_mul_start <= 1'b1;
                        r_state     <= S_D1;
                    end
                end
                S_D1: begin
                    if (mul_done) begin
                        r_mul_a     <= mul_p[PSLC_A_W-1:0];
                        r_mul_b     <= K1000;
                        r_mul_start <= 1'b1;
                        r_state     <= S_D2;
                    end
                end
                S_D2: begin
                    if (mul_done) begin
                        r_div_num   <= mul_p[PSLC_N_W-1:0];
                        r_div_den   <= r_ms;
                        r_div_start <= 1'b1;
                        r_state     <= S_DDIV;
                    end
                end
                S_DDIV: begin
                    if (div_done) begin
                        r_d         <= quo_signed;
                        r_mul_a     <= PSLC_A_W'(r_slew);
                        r_mul_b     <= PSLC_B_W'(r_ms);
                        r_mul_start <= 1'b1;
                        r_state     <= S_MC;
                    end
                end
                S_MC: begin
                    if (mul_done) begin
                        r_div_num   <= mul_p[PSLC_N_W-1:0];
                        r_div_den   <= PSLC_DEN_W'(K1000);
                        r_div_start <= 1'b1;
                        r_state     <= S_MCDIV;
                    end
                end
                S_MCDIV: begin
                    if (div_done) begin
                        r_mc    <= div_q[30:0];
                        r_state <= S_SUM;
                    end
                end
                S_SUM: begin
                    r_sum   <= tot[63] ? -$signed(tot_shift) : $signed(tot_shift);
                    r_state <= S_CLAMP;
                end
                S_CLAMP: begin
                    r_result     <= 16'(clamped);
                    r_prev_drive <= 16'(clamped);
                    r_prev_err   <= r_err;
                    r_state      <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        r_drive     <= r_result;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    pslc_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_mul_start),
        .i_a     (r_mul_a),
        .i_b     (r_mul_b),
        .o_done  (mul_done),
        .o_p     (mul_p)
    );

    pslc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_start),
        .i_num   (r_div_num),
        .i_den   (r_div_den),
        .o_done  (div_done),
        .o_quo   (div_q)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_drive     = r_drive;

`ifndef ASSERT_OFF
    // An accepted transaction closes the input until it is done
    a_in_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input open right after accepting a transaction");

    // The integral cannot move before the controller is armed
    a_esum_unarmed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_armed |-> (r_esum == '0))
        else $error("integral changed before arming");

    // Delivered drive stays inside the output range
    a_drive_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_drive >= -16'sd32512 && o_drive <= 16'sd32512))
        else $error("drive out of range");

    // The shared units never finish in the same cycle
    a_one_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mul_done && div_done))
        else $error("multiplier and divider both finished");
`endif

endmodule
